FILE: hw/rtl/oaf_pkg.sv
// Shared constants and types for the overlapping audio framer.
`default_nettype none
package oaf_pkg;
	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 7;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	typedef enum logic {
		REG_STEP_SIZE   = 1'b0,
		REG_WINDOW_SIZE = 1'b1
	} reg_idx_t;
endpackage
`default_nettype wire

FILE: hw/rtl/oaf_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none
module oaf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/oaf_fifo.sv
// Small flip-flop FIFO used for the window job queue and the output buffer.
`default_nettype none
module oaf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign dout    = data_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= din;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/oaf_front.sv
// Front end: takes samples, writes the ring, tracks fill and hop, queues window jobs.
`default_nettype none
module oaf_front import oaf_pkg::*; #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [SAMPLE_W-1:0]          sample,
	input  logic                                restart,
	input  logic [CFG_W-1:0]                    step_size,
	input  logic [CFG_W-1:0]                    window_size,
	input  logic                                job_full,
	input  logic                                job_empty,
	input  logic [$clog2(2*MAX_WINDOW)-1:0]     head_start,
	output logic                                wr_en,
	output logic [$clog2(2*MAX_WINDOW)-1:0]     wr_addr,
	output logic [SAMPLE_W-1:0]                 wr_data,
	output logic                                job_push,
	output logic [$clog2(2*MAX_WINDOW)-1:0]     job_start,
	output logic [$clog2(MAX_WINDOW+1)-1:0]     job_len
);
	localparam int RING = 2 * MAX_WINDOW;
	localparam int PW   = $clog2(RING);
	localparam int LW   = $clog2(MAX_WINDOW + 1);
	localparam int HW   = $clog2(MAX_WINDOW);

	logic [PW-1:0] wp_q;
	logic [LW-1:0] fill_q;
	logic [HW-1:0] hop_q;

	logic          accept;
	logic [LW-1:0] w_eff;
	logic [LW-1:0] s_eff;
	logic [LW-1:0] fill_base;
	logic [HW-1:0] hop_base;
	logic [LW-1:0] fill_new;
	logic [HW-1:0] hop_new;
	logic          emit;
	logic [PW:0]   start_sum;

	// ring write must never land on the oldest window still being read
	assign full   = job_full || (!job_empty && (wp_q == head_start));
	assign accept = push && !full;

	always_comb begin
		if (window_size == '0) begin
			w_eff = LW'(1);
		end else if (window_size > CFG_W'(MAX_WINDOW)) begin
			w_eff = LW'(MAX_WINDOW);
		end else begin
			w_eff = LW'(window_size);
		end
		if (step_size == '0) begin
			s_eff = LW'(1);
		end else if (step_size > CFG_W'(w_eff)) begin
			s_eff = w_eff;
		end else begin
			s_eff = LW'(step_size);
		end
	end

	always_comb begin
		fill_base = restart ? '0 : fill_q;
		hop_base  = restart ? '0 : hop_q;
		fill_new  = (fill_base < LW'(MAX_WINDOW)) ? fill_base + 1'b1 : fill_base;
		emit      = 1'b0;
		hop_new   = '0;
		if (fill_new < w_eff) begin
			hop_new = '0;
		end else if (fill_base < w_eff) begin
			emit = 1'b1;
		end else if ((LW'(hop_base) + 1'b1) >= s_eff) begin
			emit = 1'b1;
		end else begin
			hop_new = hop_base + 1'b1;
		end
	end

	always_comb begin
		start_sum = (PW+1)'(wp_q) + (PW+1)'(RING + 1) - (PW+1)'(w_eff);
		if (start_sum >= (PW+1)'(RING)) begin
			start_sum = start_sum - (PW+1)'(RING);
		end
	end

	assign wr_en     = accept;
	assign wr_addr   = wp_q;
	assign wr_data   = sample;
	assign job_push  = accept && emit;
	assign job_start = start_sum[PW-1:0];
	assign job_len   = w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			hop_q  <= '0;
		end else if (accept) begin
			wp_q   <= (wp_q == PW'(RING - 1)) ? '0 : wp_q + 1'b1;
			fill_q <= fill_new;
			hop_q  <= hop_new;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/oaf_back.sv
// Back end: walks the head window job through the ring and feeds the output buffer.
`default_nettype none
module oaf_back #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	input  logic [$clog2(2*MAX_WINDOW)-1:0] job_start,
	input  logic [$clog2(MAX_WINDOW+1)-1:0] job_len,
	output logic                            job_pop,
	input  logic [1:0]                      out_count,
	input  logic                            out_pop,
	output logic                            rd_en,
	output logic [$clog2(2*MAX_WINDOW)-1:0] rd_addr,
	output logic                            out_push,
	output logic                            out_last
);
	localparam int RING = 2 * MAX_WINDOW;
	localparam int PW   = $clog2(RING);
	localparam int LW   = $clog2(MAX_WINDOW + 1);

	logic [LW-1:0] k_q;
	logic          rd_v_s1;
	logic          last_s1;
	logic          last_k;
	logic          issue;
	logic [2:0]    used;
	logic [PW:0]   addr_sum;

	// two-entry output buffer: count beats held plus the read in flight
	assign used   = 3'(out_count) + 3'(rd_v_s1);
	assign issue  = job_valid && (used < (3'd2 + 3'(out_pop)));
	assign last_k = (k_q == job_len - LW'(1));

	always_comb begin
		addr_sum = (PW+1)'(job_start) + (PW+1)'(k_q);
		if (addr_sum >= (PW+1)'(RING)) begin
			addr_sum = addr_sum - (PW+1)'(RING);
		end
	end

	assign rd_en    = issue;
	assign rd_addr  = addr_sum[PW-1:0];
	assign job_pop  = issue && last_k;
	assign out_push = rd_v_s1;
	assign out_last = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (issue) begin
				k_q <= last_k ? '0 : k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= issue && last_k;
	end
endmodule
`default_nettype wire

FILE: hw/rtl/overlapping_audio_framer_core.sv
// Overlapping audio framer top level: APB registers, ring RAM, front, job queue, back.
`default_nettype none
// Takes one signed 16-bit sample per push beat and, once window_size samples have arrived
// since the last restart, emits the newest window_size samples oldest first at every
// step_size-th sample, with last set on the final beat. A window of w samples is read
// from the ring RAM into the output buffer at one beat per cycle while that buffer has
// room, for the job at the head of the job queue; with step 1 the sustained rate is set by
// the single read port of the ring RAM. Up to two windows wait in the job queue; full
// rises when that queue is full or when the next ring write would reach the oldest
// window not yet read out. Registers: step_size at byte 0, window_size at byte 4.
module overlapping_audio_framer_core import oaf_pkg::*; #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [APB_AW-1:0]          paddr,
	input  logic [APB_DW-1:0]          pwdata,
	output logic [APB_DW-1:0]          prdata,
	output logic                       pready,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       restart,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [SAMPLE_W-1:0] window_sample,
	output logic                       last
);
	localparam int RING = 2 * MAX_WINDOW;
	localparam int PW   = $clog2(RING);
	localparam int LW   = $clog2(MAX_WINDOW + 1);
	localparam int JW   = PW + LW;
	localparam int OW   = SAMPLE_W + 1;

	logic [CFG_W-1:0]    step_q;
	logic [CFG_W-1:0]    win_q;
	reg_idx_t            reg_sel;

	logic                wr_en;
	logic [PW-1:0]       wr_addr;
	logic [SAMPLE_W-1:0] wr_data;
	logic                rd_en;
	logic [PW-1:0]       rd_addr;
	logic [SAMPLE_W-1:0] rd_data;

	logic                job_push;
	logic [PW-1:0]       job_start_in;
	logic [LW-1:0]       job_len_in;
	logic                job_pop;
	logic [JW-1:0]       job_head;
	logic                job_full;
	logic                job_empty;
	logic [1:0]          job_count;

	logic                out_push;
	logic                out_last;
	logic [OW-1:0]       out_head;
	logic                out_full;
	logic [1:0]          out_count;
	logic                out_pop;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= CFG_W'(1);
			win_q  <= CFG_W'(1);
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_STEP_SIZE:   step_q <= pwdata[CFG_W-1:0];
				REG_WINDOW_SIZE: win_q  <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_STEP_SIZE:   prdata = APB_DW'(step_q);
			REG_WINDOW_SIZE: prdata = APB_DW'(win_q);
			default:         prdata = '0;
		endcase
	end

	oaf_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	oaf_front #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample      (sample),
		.restart     (restart),
		.step_size   (step_q),
		.window_size (win_q),
		.job_full    (job_full),
		.job_empty   (job_empty),
		.head_start  (job_head[JW-1:LW]),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.job_push    (job_push),
		.job_start   (job_start_in),
		.job_len     (job_len_in)
	);

	oaf_fifo #(
		.WIDTH (JW),
		.DEPTH (2)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    ({job_start_in, job_len_in}),
		.pop    (job_pop),
		.dout   (job_head),
		.full   (job_full),
		.empty  (job_empty),
		.count  (job_count)
	);

	oaf_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!job_empty && (job_count != 2'd0)),
		.job_start (job_head[JW-1:LW]),
		.job_len   (job_head[LW-1:0]),
		.job_pop   (job_pop),
		.out_count (out_count),
		.out_pop   (out_pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.out_push  (out_push),
		.out_last  (out_last)
	);

	assign out_pop = pop && !empty;

	oaf_fifo #(
		.WIDTH (OW),
		.DEPTH (2)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    ({rd_data, out_last}),
		.pop    (out_pop),
		.dout   (out_head),
		.full   (out_full),
		.empty  (empty),
		.count  (out_count)
	);

	assign window_sample = signed'(out_head[OW-1:1]);
	assign last          = out_head[0] && !out_full || out_head[0];
endmodule
`default_nettype wire
